@@ sv/ids_pkg.sv @@
// Package for the identifier set: operation codes, sequencer phases and
// the control word that the sequencer broadcasts along the row of cells.
// Depends on nothing.
package ids_pkg;

    // Operation codes carried by the op field of an input word.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    // Field widths of the result word.
    localparam int POS_BITS = 6;
    localparam int CNT_BITS = 7;
    localparam int ID_PORT_BITS = 16;

    // Sequencer phases: wait for a word, compare in every cell, apply.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MATCH,
        PH_APPLY
    } t_phase;

    // Control word broadcast to every cell.
    typedef struct packed {
        logic compare;   // register the match of this cell's entry
        logic shift;     // cells at or above the match take the upper neighbour
        logic append;    // the first free cell stores the identifier
    } t_cell_ctl;

endpackage

@@ sv/id_set_with_compaction.sv @@
// Identifier set kept as a packed prefix of a row of slot cells.
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_op, i_ident) takes one word per
//   operation: add if absent, remove, or membership check (op code 3 acts
//   as a check). Output channel (o_out_valid, i_out_stall) returns one word
//   per operation: was_present, position, entry_count and full_drop.
//   Timing: an accepted word is compared in every cell, whose match flags
//   are registered in the match phase, and its result is registered in the
//   apply step. The next word may be accepted at the edge that registers
//   the result, not before; the match flags are registered before the
//   removal shift and the position chain use them.
//   A held result does not stop the next word from entering; only the
//   apply step waits while the output register is full and stalled.
//   Reset (synchronous, active low) empties the set at once: every cell's
//   valid bit clears, the count goes to zero and no result is pending.
//   An add to a full table stores nothing and sets full_drop.
// Depends on ids_pkg and ids_cell.
module id_set_with_compaction
    import ids_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int ID_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_op,
    input  logic [ID_PORT_BITS-1:0] i_ident,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_was_present,
    output logic [POS_BITS-1:0]     o_position,
    output logic [CNT_BITS-1:0]     o_entry_count,
    output logic                    o_full_drop
);

    localparam int KEY_W = (ID_BITS < ID_PORT_BITS) ? ID_BITS : ID_PORT_BITS;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    t_phase           r_phase, n_phase;
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_id;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;
    logic             r_was_present;
    logic [IDX_W-1:0] r_position;
    logic [CNT_W-1:0] r_entry_count;
    logic             r_full_drop;

    logic             w_accept;
    logic             w_out_blocked;
    logic             w_apply;
    logic             w_found;
    logic             w_full;
    logic             w_is_add;
    logic             w_is_rm;
    logic [IDX_W-1:0] w_found_pos;
    t_cell_ctl        w_ctl;

    // Neighbour links along the row; index CAPACITY is the empty top end.
    logic [KEY_W-1:0] w_slot   [CAPACITY+1];
    logic             w_valid  [CAPACITY+1];
    logic             w_prefix [CAPACITY+1];
    logic [IDX_W-1:0] w_pos    [CAPACITY+1];

    logic [IDX_W+POS_BITS-1:0] w_pos_ext;
    logic [CNT_W+CNT_BITS-1:0] w_cnt_ext;

    // Handshake and phase decode.
    assign w_out_blocked = r_out_valid && i_out_stall;
    assign w_apply       = (r_phase == PH_APPLY) && !w_out_blocked;
    assign o_in_stall    = (r_phase == PH_MATCH) || ((r_phase == PH_APPLY) && w_out_blocked);
    assign w_accept      = i_in_valid && !o_in_stall;

    // Phase register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Next phase: a new word may enter in the same cycle as the apply step.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (w_accept) n_phase = PH_MATCH;
            end
            PH_MATCH: begin
                n_phase = PH_APPLY;
            end
            PH_APPLY: begin
                if (w_apply) n_phase = w_accept ? PH_MATCH : PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Operation register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_op;
            r_id <= i_ident[KEY_W-1:0];
        end
    end

    // Decode of the held operation and the row's summary.
    assign w_is_add    = (r_op == OP_ADD);
    assign w_is_rm     = (r_op == OP_REMOVE);
    assign w_full      = (r_count == CNT_FULL);
    assign w_found     = w_prefix[CAPACITY];
    assign w_found_pos = w_pos[CAPACITY];

    assign w_ctl.compare = (r_phase == PH_MATCH);
    assign w_ctl.shift   = w_apply && w_is_rm && w_found;
    assign w_ctl.append  = w_apply && w_is_add && !w_found && !w_full;

    // Row of slot cells.
    assign w_slot[CAPACITY]  = '0;
    assign w_valid[CAPACITY] = 1'b0;
    assign w_prefix[0]       = 1'b0;
    assign w_pos[0]          = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic w_low_valid;
        if (g == 0) begin : g_bottom
            assign w_low_valid = 1'b1;
        end else begin : g_inner
            assign w_low_valid = w_valid[g-1];
        end

        ids_cell #(
            .KEY_W (KEY_W),
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_id        (r_id),
            .i_up_slot   (w_slot[g+1]),
            .i_up_valid  (w_valid[g+1]),
            .i_low_valid (w_low_valid),
            .i_prefix    (w_prefix[g]),
            .i_pos       (w_pos[g]),
            .o_slot      (w_slot[g]),
            .o_valid     (w_valid[g]),
            .o_prefix    (w_prefix[g+1]),
            .o_pos       (w_pos[g+1])
        );
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_ctl.append) begin
            r_count <= r_count + 1'b1;
        end else if (w_ctl.shift) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_was_present <= w_found;
            r_full_drop   <= w_is_add && !w_found && w_full;
            if (w_found) begin
                r_position <= w_found_pos;
            end else if (w_ctl.append) begin
                r_position <= r_count[IDX_W-1:0];
            end else begin
                r_position <= '0;
            end
            if (w_ctl.append) begin
                r_entry_count <= r_count + 1'b1;
            end else if (w_ctl.shift) begin
                r_entry_count <= r_count - 1'b1;
            end else begin
                r_entry_count <= r_count;
            end
        end
    end

    // Fit position and count to their field widths.
    assign w_pos_ext = {{POS_BITS{1'b0}}, r_position};
    assign w_cnt_ext = {{CNT_BITS{1'b0}}, r_entry_count};

    assign o_out_valid   = r_out_valid;
    assign o_was_present = r_was_present;
    assign o_position    = w_pos_ext[POS_BITS-1:0];
    assign o_entry_count = w_cnt_ext[CNT_BITS-1:0];
    assign o_full_drop   = r_full_drop;

endmodule

@@ sv/ids_cell.sv @@
// One slot of the identifier set: stored entry, valid bit and match flag.
// Hands its entry down to the lower neighbour when an entry below is removed.
// Depends on ids_pkg.
module ids_cell
    import ids_pkg::*;
#(
    parameter int KEY_W = 16,
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_id,
    input  logic [KEY_W-1:0] i_up_slot,
    input  logic             i_up_valid,
    input  logic             i_low_valid,
    input  logic             i_prefix,
    input  logic [IDX_W-1:0] i_pos,
    output logic [KEY_W-1:0] o_slot,
    output logic             o_valid,
    output logic             o_prefix,
    output logic [IDX_W-1:0] o_pos
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [KEY_W-1:0] r_slot;
    logic             r_valid;
    logic             r_match;
    logic             w_at_or_above;

    // This cell lies at or above the matching entry.
    assign w_at_or_above = i_prefix | r_match;

    // Valid bit and match flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.compare) begin
                r_match <= r_valid && (r_slot == i_id);
            end
            if (i_ctl.shift && w_at_or_above) begin
                r_valid <= i_up_valid;
            end else if (i_ctl.append && !r_valid && i_low_valid) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Stored entry: moves down on a removal, or takes the new identifier
    // if this is the first free slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && w_at_or_above) begin
            r_slot <= i_up_slot;
        end else if (i_ctl.append && !r_valid && i_low_valid) begin
            r_slot <= i_id;
        end
    end

    assign o_slot   = r_slot;
    assign o_valid  = r_valid;
    assign o_prefix = w_at_or_above;
    assign o_pos    = r_match ? (i_pos | MY_IDX) : i_pos;

endmodule

@@ sv/ids_checker.sv @@
// Port-level checks for the identifier set, and the bind that attaches
// them to every instance of the top level.
// Depends on ids_pkg and id_set_with_compaction.
module ids_checker
    import ids_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic                    o_was_present,
    input logic [POS_BITS-1:0]     o_position,
    input logic [CNT_BITS-1:0]     o_entry_count,
    input logic                    o_full_drop
);

    // The count shown never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_entry_count) <= CAPACITY))
        else $error("entry count above capacity");

    // A refused add concerns an absent identifier and reports slot zero.
    a_drop_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_drop) |-> (!o_was_present && (o_position == '0)))
        else $error("refused add reports a present identifier or a slot");

    // The block stalls right after accepting a word.
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("word accepted on consecutive cycles");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_was_present) && $stable(o_position)
             && $stable(o_entry_count) && $stable(o_full_drop)))
        else $error("stalled result word changed");

endmodule

bind id_set_with_compaction ids_checker #(
    .CAPACITY (CAPACITY)
) u_ids_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_was_present (o_was_present),
    .o_position    (o_position),
    .o_entry_count (o_entry_count),
    .o_full_drop   (o_full_drop)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for id_set_with_compaction: it drives add, remove and check words
// and compares every result word with the output of a model of the packed set.
// Depends on ids_pkg and the id_set_with_compaction block.
module tb_top
    import ids_pkg::*;
();

    localparam int TABLE_SLOTS = 64;
    localparam int ID_WIDTH = 16;
    // The spare op code behaves as a membership check.
    localparam logic [1:0] OP_SPARE_CHECK = 2'd3;
    localparam int RANDOM_WORDS = 1250;
    localparam int CYCLE_LIMIT = 800000;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic                was_present;
        logic [POS_BITS-1:0] position;
        logic [CNT_BITS-1:0] entry_count;
        logic                full_drop;
    } t_result;

    // Model of the packed set and the queue of results it still awaits.
    class id_set_tracker;
        logic [ID_PORT_BITS-1:0] ids [TABLE_SLOTS];
        int held;
        t_result awaited[$];
        int errors;
        int checked;
        int drops;
        int compactions;
        int peak;

        function new();
            held = 0;
            errors = 0;
            checked = 0;
            drops = 0;
            compactions = 0;
            peak = 0;
        endfunction

        function void complain(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endfunction

        // Applies one accepted word to the set and queues its result.
        function void note_word(logic [1:0] op, logic [ID_PORT_BITS-1:0] ident);
            bit found;
            int where;
            t_result r;
            found = 1'b0;
            where = 0;
            for (int i = 0; i < held; i++) begin
                if (!found && ids[i] == ident) begin
                    found = 1'b1;
                    where = i;
                end
            end
            r.full_drop = 1'b0;
            r.position = found ? POS_BITS'(where) : '0;
            case (op)
                OP_ADD: begin
                    if (!found) begin
                        if (held < TABLE_SLOTS) begin
                            ids[held] = ident;
                            r.position = POS_BITS'(held);
                            held++;
                        end else begin
                            r.full_drop = 1'b1;
                            drops++;
                        end
                    end
                end
                OP_REMOVE: begin
                    if (found) begin
                        for (int i = where; i + 1 < held; i++) ids[i] = ids[i + 1];
                        held--;
                        compactions++;
                    end
                end
                default: ;
            endcase
            r.was_present = found;
            r.entry_count = CNT_BITS'(held);
            if (held > peak) peak = held;
            awaited.push_back(r);
        endfunction

        // Compares one delivered result with the oldest awaited one.
        function void check_word(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                complain($sformatf(
                    "unexpected result: was_present=%0b position=%0d count=%0d drop=%0b",
                    got.was_present, got.position, got.entry_count, got.full_drop));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.was_present !== want.was_present)
                complain($sformatf("was_present expected %0b, got %0b",
                                   want.was_present, got.was_present));
            if (got.position !== want.position)
                complain($sformatf("position expected %0d, got %0d", want.position, got.position));
            if (got.entry_count !== want.entry_count)
                complain($sformatf("entry_count expected %0d, got %0d",
                                   want.entry_count, got.entry_count));
            if (got.full_drop !== want.full_drop)
                complain($sformatf("full_drop expected %0b, got %0b", want.full_drop, got.full_drop));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [1:0] i_op = OP_ADD;
    logic [ID_PORT_BITS-1:0] i_ident = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic o_was_present;
    logic [POS_BITS-1:0] o_position;
    logic [CNT_BITS-1:0] o_entry_count;
    logic o_full_drop;

    id_set_tracker tracker;
    int gap_pct = 30;
    int rx_pct = 30;
    int hold_reqs = 0;
    int hold_done = 0;
    int hold_left = 0;
    int stall_left = 0;
    int words_sent = 0;
    int cycles = 0;
    logic [ID_PORT_BITS-1:0] pool[$];

    id_set_with_compaction #(
        .CAPACITY(TABLE_SLOTS),
        .ID_BITS (ID_WIDTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_ident      (i_ident),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_was_present(o_was_present),
        .o_position   (o_position),
        .o_entry_count(o_entry_count),
        .o_full_drop  (o_full_drop)
    );

    always #1 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_idle(int pct);
        if (pct == 0 || $urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    // Receiver: one long hold when asked, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_done != hold_reqs) begin
            hold_done <= hold_reqs;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_left <= pick_idle(rx_pct);
            i_out_stall <= (stall_left != 0);
        end
    end

    // Result monitor: every delivered word goes to the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_word(
                t_result'({o_was_present, o_position, o_entry_count, o_full_drop}));
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results awaited.",
                     cycles, tracker.outstanding());
            $display("** id_set_with_compaction: FAILED **");
            $finish;
        end
    end

    // Offers one word after a random gap and waits until it is taken.
    task automatic send_word(input logic [1:0] op, input logic [ID_PORT_BITS-1:0] ident);
        int idle;
        idle = pick_idle(gap_pct);
        repeat (idle) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_ident <= ident;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_word(op, ident);
        words_sent++;
    endtask

    // Stray word: spare op code or an identifier outside the working pool.
    task automatic send_stray();
        logic [ID_PORT_BITS-1:0] wild;
        wild = ID_PORT_BITS'($urandom());
        case ($urandom_range(2))
            0: send_word(OP_SPARE_CHECK, wild);
            1: send_word(OP_REMOVE, wild);
            default: send_word(OP_SPARE_CHECK, pool[$urandom_range(pool.size() - 1)]);
        endcase
    endtask

    // Fills the pool with distinct random identifiers.
    task automatic build_pool(input int n);
        logic [ID_PORT_BITS-1:0] cand;
        bit dup;
        pool.delete();
        while (pool.size() < n) begin
            cand = ID_PORT_BITS'($urandom());
            dup = 1'b0;
            foreach (pool[k]) if (pool[k] == cand) dup = 1'b1;
            if (!dup) pool.push_back(cand);
        end
    endtask

    task automatic shuffle_pool();
        int j;
        logic [ID_PORT_BITS-1:0] tmp;
        for (int i = pool.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
    endtask

    function automatic logic [ID_PORT_BITS-1:0] any_pooled();
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    initial begin
        int round;
        int target;
        int pick;
        tracker = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: empty-set lookups, extreme identifiers, duplicates,
        // removal from the middle, the front and the end, and the spare op code.
        send_word(OP_CHECK, 16'h1234);
        send_word(OP_REMOVE, 16'h1234);
        send_word(OP_ADD, 16'h0000);
        send_word(OP_ADD, 16'hFFFF);
        send_word(OP_ADD, 16'h8000);
        send_word(OP_ADD, 16'h0001);
        send_word(OP_ADD, 16'hFFFF);
        send_word(OP_CHECK, 16'h8000);
        send_word(OP_SPARE_CHECK, 16'h0001);
        send_word(OP_SPARE_CHECK, 16'h4242);
        send_word(OP_REMOVE, 16'hFFFF);
        send_word(OP_CHECK, 16'h8000);
        send_word(OP_CHECK, 16'h0001);
        send_word(OP_REMOVE, 16'h0000);
        send_word(OP_REMOVE, 16'h0001);
        send_word(OP_REMOVE, 16'h0001);
        send_word(OP_CHECK, 16'h8000);
        send_word(OP_REMOVE, 16'h8000);
        send_word(OP_ADD, 16'h5A5A);
        send_word(OP_REMOVE, 16'h5A5A);
        send_word(OP_CHECK, 16'hFFFF);

        // Random rounds: fill past capacity, mixed traffic, drain, then churn
        // on a handful of identifiers. Idling differs from round to round.
        target = words_sent + RANDOM_WORDS;
        round = 0;
        while (words_sent < target) begin
            case (round % 4)
                0: begin gap_pct = 25; rx_pct = 25; end
                1: begin gap_pct = 0;  rx_pct = 0;  end
                2: begin gap_pct = 50; rx_pct = 10; end
                default: begin gap_pct = 10; rx_pct = 50; end
            endcase
            build_pool($urandom_range(72, 66));
            // The receiver holds off while the fill keeps offering words.
            if (round == 0) hold_reqs++;

            foreach (pool[k]) begin
                send_word(OP_ADD, pool[k]);
                pick = $urandom_range(99);
                if (pick < 20) send_word(OP_CHECK, any_pooled());
                else if (pick < 25) send_stray();
            end
            repeat (6) send_word(OP_ADD, any_pooled());

            repeat (120) begin
                pick = $urandom_range(99);
                if (pick < 35) send_word(OP_ADD, any_pooled());
                else if (pick < 65) send_word(OP_REMOVE, any_pooled());
                else if (pick < 90) send_word(OP_CHECK, any_pooled());
                else send_stray();
            end

            shuffle_pool();
            foreach (pool[k]) begin
                send_word(OP_REMOVE, pool[k]);
                if ($urandom_range(99) < 15) send_word(OP_CHECK, any_pooled());
            end

            pool = pool[0:5];
            repeat (40) begin
                case ($urandom_range(2))
                    0: send_word(OP_ADD, any_pooled());
                    1: send_word(OP_REMOVE, any_pooled());
                    default: send_word(OP_CHECK, any_pooled());
                endcase
            end
            round++;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Let every awaited result arrive, then watch for strays.
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d words in %0d random rounds; %0d results checked,",
                 words_sent, round, tracker.checked);
        $display("peak occupancy %0d of %0d; adds refused on a full table: %0d; %s %0d.",
                 tracker.peak, TABLE_SLOTS, tracker.drops,
                 "removals that compacted the table:", tracker.compactions);
        if (tracker.errors == 0) begin
            $display("** id_set_with_compaction: PASSED **");
        end else begin
            $display("** id_set_with_compaction: FAILED **");
        end
        $finish;
    end

endmodule
